### src/mtfol_pkg.sv
// Shared types and constants for the move-to-front/back order list.
`default_nettype none
package mtfol_pkg;

   localparam int MAX_ELEMENTS_DEF = 64;
   localparam int VAL_W            = 7;
   localparam logic [VAL_W-1:0] ELEMENT_COUNT_RST = 7'd64;

   typedef enum logic [1:0] {
      OP_INIT = 2'd0,
      OP_HEAD = 2'd1,
      OP_TAIL = 2'd2,
      OP_DUMP = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type       opcode;
      logic [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [VAL_W-1:0] element;
      logic             last;
   } rsp_type;

   // wave passed between neighboring cells
   typedef struct packed {
      logic             act;
      logic [VAL_W-1:0] carry;
   } wave_type;

   // controls broadcast to every cell
   typedef struct packed {
      logic             init;
      logic             inj_head;
      logic             inj_tail;
      logic             rotate;
      logic [VAL_W-1:0] key;
      logic [VAL_W-1:0] count;
   } cell_ctl_type;

endpackage
`default_nettype wire

### src/mtfol_cell.sv
// One position of the order: holds the value there and relays shift waves.
`default_nettype none
module mtfol_cell #(
   parameter int INDEX = 0
) (
   input  wire                                clock,
   input  wire                                reset,
   input  mtfol_pkg::cell_ctl_type            ctl,
   input  mtfol_pkg::wave_type                r_in,
   input  mtfol_pkg::wave_type                l_in,
   input  wire [mtfol_pkg::VAL_W-1:0]         right_val,
   input  wire [mtfol_pkg::VAL_W-1:0]         wrap_val,
   output logic [mtfol_pkg::VAL_W-1:0]        val,
   output mtfol_pkg::wave_type                r_out,
   output mtfol_pkg::wave_type                l_out
);
   import mtfol_pkg::*;

   logic [VAL_W-1:0] val_ff, val_in;
   wave_type         r_ff, r_in_nx, l_ff, l_in_nx;
   logic             at_tail;
   logic             l_arrive;
   logic [VAL_W-1:0] l_carry;

   assign at_tail  = (VAL_W'(INDEX + 1) == ctl.count);
   assign l_arrive = l_in.act | (ctl.inj_tail & at_tail);
   assign l_carry  = (ctl.inj_tail & at_tail) ? ctl.key : l_in.carry;

   always_comb begin
      val_in  = val_ff;
      r_in_nx = '0;
      l_in_nx = '0;
      if (ctl.init) begin
         val_in = VAL_W'(INDEX + 1);
      end else if (ctl.rotate) begin
         val_in = at_tail ? wrap_val : right_val;
      end else if (r_in.act) begin
         val_in = r_in.carry;
         if (val_ff != ctl.key) begin
            r_in_nx.act   = 1'b1;
            r_in_nx.carry = val_ff;
         end
      end else if (l_arrive) begin
         val_in = l_carry;
         if (val_ff != ctl.key) begin
            l_in_nx.act   = 1'b1;
            l_in_nx.carry = val_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      r_ff.carry <= r_in_nx.carry;
      l_ff.carry <= l_in_nx.carry;
      if (reset) begin
         r_ff.act <= 1'b0;
         l_ff.act <= 1'b0;
      end else begin
         r_ff.act <= r_in_nx.act;
         l_ff.act <= l_in_nx.act;
      end
   end

   assign val   = val_ff;
   assign r_out = r_ff;
   assign l_out = l_ff;

endmodule
`default_nettype wire

### src/mtfol_ctrl.sv
// Sequencer: command decode, list length, dump counter and wave launch.
`default_nettype none
module mtfol_ctrl #(
   parameter int MAX_ELEMENTS = mtfol_pkg::MAX_ELEMENTS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  mtfol_pkg::req_type           req_beat,
   input  wire                          csr_we,
   input  wire [mtfol_pkg::VAL_W-1:0]   csr_wdata,
   input  wire                          any_act,
   output logic                         busy,
   output logic                         rsp_valid,
   output logic                         rsp_last,
   output mtfol_pkg::cell_ctl_type      ctl
);
   import mtfol_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOAD = 4'b0010,
      ST_MOVE = 4'b0100,
      ST_DUMP = 4'b1000
   } state_type;

   localparam logic [VAL_W-1:0] MAX_V = VAL_W'(MAX_ELEMENTS);

   state_type        state_ff, state_in;
   logic [VAL_W-1:0] elem_cnt_ff, elem_cnt_in;
   logic [VAL_W-1:0] count_ff, count_in;
   logic [VAL_W-1:0] left_ff, left_in;
   logic [VAL_W-1:0] key_ff, key_in;
   logic             tail_ff, tail_in;
   logic             accept;
   logic             move_ok;

   assign accept  = start & (state_ff == ST_IDLE);
   assign move_ok = (count_ff != '0) && (req_beat.value != '0) &&
                    (req_beat.value <= count_ff);

   always_comb begin
      state_in    = state_ff;
      elem_cnt_in = csr_we ? csr_wdata : elem_cnt_ff;
      count_in    = count_ff;
      left_in     = left_ff;
      key_in      = key_ff;
      tail_in     = tail_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_beat.opcode)
                  OP_INIT: begin
                     count_in = (elem_cnt_ff > MAX_V) ? MAX_V : elem_cnt_ff;
                  end
                  OP_HEAD, OP_TAIL: begin
                     if (move_ok) begin
                        key_in   = req_beat.value;
                        tail_in  = (req_beat.opcode == OP_TAIL);
                        state_in = ST_LOAD;
                     end
                  end
                  OP_DUMP: begin
                     if (count_ff != '0) begin
                        left_in  = count_ff;
                        state_in = ST_DUMP;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_LOAD: state_in = ST_MOVE;
         ST_MOVE: begin
            if (!any_act) begin
               state_in = ST_IDLE;
            end
         end
         ST_DUMP: begin
            left_in = left_ff - VAL_W'(1);
            if (left_ff == VAL_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      tail_ff <= tail_in;
      if (reset) begin
         state_ff    <= ST_IDLE;
         elem_cnt_ff <= ELEMENT_COUNT_RST;
         count_ff    <= '0;
         left_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         elem_cnt_ff <= elem_cnt_in;
         count_ff    <= count_in;
         left_ff     <= left_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DUMP);
   assign rsp_last  = (left_ff == VAL_W'(1));

   always_comb begin
      ctl          = '0;
      ctl.init     = accept && (req_beat.opcode == OP_INIT);
      ctl.inj_head = (state_ff == ST_LOAD) && !tail_ff;
      ctl.inj_tail = (state_ff == ST_LOAD) && tail_ff;
      ctl.rotate   = (state_ff == ST_DUMP);
      ctl.key      = key_ff;
      ctl.count    = count_ff;
   end

endmodule
`default_nettype wire

### src/move_to_front_back_order_list_unit.sv
// Top level: move-to-front/back order list built as a row of position cells.
// Init or an ignored move: taken while idle, busy never rises. Move to head/tail:
// busy in the load and move states while the shift wave crosses p cells (1 up to
// the list length), one cell per cycle. Dump of n values: n beats back to back
// from the cycle after the accepting edge as the row rotates; busy throughout.
// Reset empties the list and sets element_count to 64; the receiver cannot stall.
`default_nettype none
module move_to_front_back_order_list_unit #(
   parameter int MAX_ELEMENTS = mtfol_pkg::MAX_ELEMENTS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  mtfol_pkg::req_type           req_beat,
   output logic                         rsp_valid,
   output mtfol_pkg::rsp_type           rsp_beat,
   input  wire                          csr_we,
   input  wire [mtfol_pkg::VAL_W-1:0]   csr_wdata
);
   import mtfol_pkg::*;

   cell_ctl_type     ctl;
   logic             rsp_last;
   logic             any_act;
   logic [VAL_W-1:0] vals [MAX_ELEMENTS];
   wave_type         r_w  [MAX_ELEMENTS];
   wave_type         l_w  [MAX_ELEMENTS];
   logic [MAX_ELEMENTS-1:0] acts;

   mtfol_ctrl #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_beat  (req_beat),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .any_act   (any_act),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_last  (rsp_last),
      .ctl       (ctl)
   );

   for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
      wave_type         r_src, l_src;
      logic [VAL_W-1:0] right_src;
      if (i == 0) begin : g_first
         assign r_src.act   = ctl.inj_head;
         assign r_src.carry = ctl.key;
      end else begin : g_mid_r
         assign r_src = r_w[i-1];
      end
      if (i == MAX_ELEMENTS-1) begin : g_last
         assign l_src     = '0;
         assign right_src = vals[0];
      end else begin : g_mid_l
         assign l_src     = l_w[i+1];
         assign right_src = vals[i+1];
      end
      mtfol_cell #(.INDEX(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .r_in      (r_src),
         .l_in      (l_src),
         .right_val (right_src),
         .wrap_val  (vals[0]),
         .val       (vals[i]),
         .r_out     (r_w[i]),
         .l_out     (l_w[i])
      );
      assign acts[i] = r_w[i].act | l_w[i].act;
   end

   assign any_act          = |acts;
   assign rsp_beat.element = vals[0];
   assign rsp_beat.last    = rsp_last;

endmodule
`default_nettype wire

### src/mtfol_checker.sv
// Port-level checks for the order list unit, bound to the top level.
`default_nettype none
module mtfol_checker (
   input wire                        clock,
   input wire                        reset,
   input wire                        start,
   input wire                        busy,
   input mtfol_pkg::req_type         req_beat,
   input wire                        rsp_valid,
   input mtfol_pkg::rsp_type         rsp_beat
);
   import mtfol_pkg::*;

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result beat while idle");

   a_no_rsp_non_dump: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_beat.opcode != OP_DUMP) |=> !rsp_valid)
      else $error("result beat after a non-dump command");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_beat.last) |=> !rsp_valid)
      else $error("beat after last");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_beat.last) |=> rsp_valid)
      else $error("dump run broken before last");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy)
      else $error("busy after reset");

endmodule

bind move_to_front_back_order_list_unit mtfol_checker u_chk (.*);
`default_nettype wire

### tb/sv/tb_move_to_front_back_order_list_unit.sv
// Testbench for the move-to-front/back order list: directed and random commands against a predictor.
module tb_move_to_front_back_order_list_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import mtfol_pkg::*;

   localparam int NMAX          = MAX_ELEMENTS_DEF;
   localparam int SETTLE_CYCLES = NMAX + 16;
   localparam int STALL_LIMIT   = 2000;
   localparam int PRINT_LIMIT   = 50;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   req_type            req_beat;
   logic               rsp_valid;
   rsp_type            rsp_beat;
   logic               csr_we;
   logic [VAL_W-1:0]   csr_wdata;

   // predicted list state
   logic [VAL_W-1:0]   order_next [0:NMAX];
   logic [VAL_W-1:0]   order_prev [0:NMAX];
   logic [VAL_W-1:0]   order_head;
   logic [VAL_W-1:0]   order_tail;
   logic [VAL_W-1:0]   order_len;
   logic [VAL_W-1:0]   count_reg;
   rsp_type            dump_beats [$];

   rsp_type            want_beat;
   int                 error_count;
   int                 stall_cycles;
   bit                 idle_enable;

   move_to_front_back_order_list_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_beat  (rsp_beat),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= PRINT_LIMIT) begin
         $display("ERROR @%0t: %s", $time, what);
      end
   endtask

   function automatic void rebuild_order();
      int n;
      n = (count_reg > NMAX) ? NMAX : int'(count_reg);
      for (int v = 0; v <= NMAX; v++) begin
         order_next[v] = '0;
         order_prev[v] = '0;
      end
      for (int v = 1; v <= n; v++) begin
         order_prev[v] = VAL_W'(v - 1);
         order_next[v] = (v < n) ? VAL_W'(v + 1) : '0;
      end
      order_len  = VAL_W'(n);
      order_head = 7'd1;
      order_tail = VAL_W'(n);
   endfunction

   function automatic void unlink_entry(input logic [VAL_W-1:0] v);
      logic [VAL_W-1:0] p;
      logic [VAL_W-1:0] nx;
      p  = order_prev[v];
      nx = order_next[v];
      if (p != 0) order_next[p] = nx;
      else order_head = nx;
      if (nx != 0) order_prev[nx] = p;
      else order_tail = p;
   endfunction

   function automatic void move_first(input logic [VAL_W-1:0] v);
      if (order_head == v) return;
      unlink_entry(v);
      order_prev[v] = '0;
      order_next[v] = order_head;
      if (order_head != 0) order_prev[order_head] = v;
      else order_tail = v;
      order_head = v;
   endfunction

   function automatic void move_last(input logic [VAL_W-1:0] v);
      if (order_tail == v) return;
      unlink_entry(v);
      order_next[v] = '0;
      order_prev[v] = order_tail;
      if (order_tail != 0) order_next[order_tail] = v;
      else order_head = v;
      order_tail = v;
   endfunction

   function automatic void update_order(input req_type r);
      logic [VAL_W-1:0] cur;
      rsp_type          b;
      case (r.opcode)
         OP_INIT: rebuild_order();
         OP_HEAD, OP_TAIL: begin
            if (order_len != 0 && r.value >= 1 && r.value <= order_len) begin
               if (r.opcode == OP_HEAD) move_first(r.value);
               else move_last(r.value);
            end
         end
         default: begin
            cur = order_head;
            for (int k = 0; k < order_len; k++) begin
               b.element = cur;
               b.last    = (k + 1 == order_len);
               dump_beats = {dump_beats, b};
               cur = (cur <= NMAX) ? order_next[cur] : '0;
            end
         end
      endcase
   endfunction

   task automatic pause_sender();
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic send_beat(input opcode_type op, input logic [VAL_W-1:0] v);
      req_type r;
      r.opcode = op;
      r.value  = v;
      start    <= 1'b1;
      req_beat <= r;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      update_order(r);
      pause_sender();
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (dump_beats.size() != 0) @(posedge clock);
   endtask

   task automatic settle();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(input logic [VAL_W-1:0] n);
      csr_we    <= 1'b1;
      csr_wdata <= n;
      @(posedge clock);
      csr_we    <= 1'b0;
      count_reg = n;
   endtask

   function automatic req_type random_command();
      req_type r;
      int      pick;
      pick    = $urandom_range(0, 99);
      r.value = VAL_W'($urandom_range(1, (order_len == 0) ? 1 : order_len));
      if (pick < 10) begin
         r.opcode = OP_DUMP;
         r.value  = VAL_W'($urandom_range(0, 127));
      end else if (pick < 12) begin
         r.opcode = OP_INIT;
         r.value  = VAL_W'($urandom_range(0, 127));
      end else begin
         r.opcode = $urandom_range(0, 1) ? OP_HEAD : OP_TAIL;
         if (pick >= 88) r.value = VAL_W'($urandom_range(0, 127));
      end
      return r;
   endfunction

   // list empty after reset: moves ignored, dump silent
   task automatic test_before_init();
      send_beat(OP_DUMP, 7'd0);
      send_beat(OP_HEAD, 7'd5);
      send_beat(OP_TAIL, 7'd5);
   endtask

   task automatic test_full_order();
      send_beat(OP_INIT, 7'd127);
      send_beat(OP_HEAD, 7'd64);
      send_beat(OP_TAIL, 7'd1);
      send_beat(OP_HEAD, 7'd64);
      send_beat(OP_TAIL, 7'd1);
      send_beat(OP_HEAD, 7'd0);
      send_beat(OP_TAIL, 7'd127);
      send_beat(OP_HEAD, 7'd65);
      send_beat(OP_DUMP, 7'd127);
   endtask

   task automatic test_count_limits();
      settle();
      write_count(7'd0);
      send_beat(OP_INIT, 7'd0);
      send_beat(OP_HEAD, 7'd1);
      send_beat(OP_DUMP, 7'd0);
      settle();
      write_count(7'd1);
      send_beat(OP_INIT, 7'd0);
      send_beat(OP_TAIL, 7'd1);
      send_beat(OP_DUMP, 7'd0);
      settle();
      write_count(7'd127);
      send_beat(OP_INIT, 7'd0);
      send_beat(OP_DUMP, 7'd0);
      settle();
      write_count(7'd2);
      send_beat(OP_INIT, 7'd0);
      send_beat(OP_TAIL, 7'd1);
      send_beat(OP_DUMP, 7'd0);
   endtask

   task automatic test_random_phases();
      req_type          r;
      logic [VAL_W-1:0] n;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       n = 7'd8;
            1:       n = VAL_W'($urandom_range(3, 20));
            2:       n = 7'd64;
            default: n = VAL_W'($urandom_range(1, 64));
         endcase
         settle();
         write_count(n);
         send_beat(OP_INIT, 7'd0);
         for (int i = 0; i < 45; i++) begin
            r = random_command();
            send_beat(r.opcode, r.value);
            if (r.opcode == OP_DUMP && $urandom_range(0, 3) == 0) drain_results();
         end
         send_beat(OP_DUMP, 7'd0);
      end
   endtask

   task automatic test_back_to_back();
      req_type r;
      settle();
      write_count(7'd12);
      send_beat(OP_INIT, 7'd0);
      for (int i = 0; i < 34; i++) begin
         r = random_command();
         send_beat(r.opcode, r.value);
      end
      send_beat(OP_DUMP, 7'd0);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (dump_beats.size() == 0) begin
            report_mismatch($sformatf("unexpected beat element=%0d last=%0b",
                                      rsp_beat.element, rsp_beat.last));
         end else begin
            want_beat = dump_beats.pop_front();
            if (rsp_beat.element !== want_beat.element) begin
               report_mismatch($sformatf("element %0d, want %0d",
                                         rsp_beat.element, want_beat.element));
            end
            if (rsp_beat.last !== want_beat.last) begin
               report_mismatch($sformatf("last %0b, want %0b (element %0d)",
                                         rsp_beat.last, want_beat.last, want_beat.element));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else if ((start && busy === 1'b0) || rsp_valid === 1'b1) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      error_count = 0;
      idle_enable = 1'b1;
      for (int i = 0; i <= NMAX; i++) begin
         order_next[i] = '0;
         order_prev[i] = '0;
      end
      order_head = 7'd1;
      order_tail = '0;
      order_len  = '0;
      count_reg  = ELEMENT_COUNT_RST;
      reset     <= 1'b1;
      start     <= 1'b0;
      req_beat  <= '0;
      csr_we    <= 1'b0;
      csr_wdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_before_init();
      test_full_order();
      test_count_limits();
      test_random_phases();
      idle_enable = 1'b0;
      test_back_to_back();
      settle();

      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
